// ----- hw/rtl/riwt_pkg.sv -----
// Package: constants, codes, types and helpers of the receive window tracker.
`default_nettype none
package riwt_pkg;

  localparam int HISTORY         = 16;
  localparam int SLOT_W          = $clog2(HISTORY);
  localparam int CNT_W           = $clog2(HISTORY);
  localparam int SUBHEADER_BYTES = 4;
  localparam int MAX_SLOT_LENGTH = 4095;
  localparam logic [15:0] MAX_MSG_RESET = 16'd512;
  localparam logic [15:0] SEQ_RESET     = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_RECEIVE   = 3'd0,
    CMD_HEARTBEAT = 3'd1,
    CMD_POP       = 3'd2,
    CMD_ACKNACK   = 3'd3,
    CMD_SOFT_RST  = 3'd4
  } cmd_t;

  localparam logic [1:0] KIND_WHOLE = 2'd0;
  localparam logic [1:0] KIND_MID   = 2'd1;
  localparam logic [1:0] KIND_LAST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK_ISSUE,
    ST_WALK,
    ST_CONS_ISSUE,
    ST_CONS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [11:0] len;
    logic [1:0]  kind;
  } slot_t;

  typedef struct packed {
    logic        readable;
    logic        stored;
    logic        available;
    logic [15:0] first_seq;
    logic [15:0] last_seq;
    logic [15:0] assembled_length;
    logic        oversize_drop;
    logic [15:0] miss_mask;
    logic        up_to_date;
  } res_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [15:0] s);
    return s[SLOT_W-1:0];
  endfunction

  // Serial number arithmetic: a comes before b.
  function automatic logic seq_lt(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d_ba;
    logic [15:0] d_ab;
    d_ba = b - a;
    d_ab = a - b;
    return (a != b) && (((a < b) && (d_ba < 16'd32767)) || ((a > b) && (d_ab > 16'd32767)));
  endfunction

  function automatic logic [11:0] payload_of(input logic [11:0] len);
    return (len > 12'(SUBHEADER_BYTES)) ? len - 12'(SUBHEADER_BYTES) : 12'd0;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/riwt_in_if.sv -----
// Interface: command item channel of the receive window tracker.
`default_nettype none
interface riwt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] seq_num;
  logic [1:0]  frag_kind;
  logic [11:0] msg_length;
  modport source (output valid, cmd, seq_num, frag_kind, msg_length, input ready);
  modport sink   (input valid, cmd, seq_num, frag_kind, msg_length, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/riwt_out_if.sv -----
// Interface: result item channel of the receive window tracker.
`default_nettype none
interface riwt_out_if;
  logic        valid;
  logic        ready;
  logic        readable;
  logic        stored;
  logic        available;
  logic [15:0] first_seq;
  logic [15:0] last_seq;
  logic [15:0] assembled_length;
  logic        oversize_drop;
  logic [15:0] miss_mask;
  logic        up_to_date;
  modport source (output valid, readable, stored, available, first_seq, last_seq,
                  assembled_length, oversize_drop, miss_mask, up_to_date, input ready);
  modport sink   (input valid, readable, stored, available, first_seq, last_seq,
                  assembled_length, oversize_drop, miss_mask, up_to_date, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/reliable_input_window_tracker.sv -----
// Top level: reliable stream receive window with slot memory and chain reassembly.
//
//  channel   dir  handshake              contents
//  items     in   valid/ready            cmd, seq_num, frag_kind, msg_length
//  results   out  valid/ready            one result item per command
//  apb       in   psel/penable/pready    message size limit at byte address 0
//
// One item at a time. Heartbeat, acknack, soft reset and plain receive pass through
// ST_EXEC and ST_DONE only. A fragment receive that stores a slot adds ST_WALK_ISSUE
// and a chain search in ST_WALK over up to HISTORY slots; a pop adds the same search plus
// ST_CONS_ISSUE and ST_CONS to consume the chain, each step being one slot memory read.
// rst sets the window numbers to SEQ_RESET, clears the slot valid bits and restores the size limit.
// A new item is taken while a result waits; its own result waits in ST_DONE.
`default_nettype none
module reliable_input_window_tracker
  import riwt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  riwt_in_if.sink          items,
  riwt_out_if.source       results,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  state_t state, state_next;

  logic [15:0] max_msg;
  logic [15:0] seq_done, seq_heard;
  logic [HISTORY-1:0] valid;

  logic [2:0]  cmd_r;
  logic [15:0] seq_r;
  logic [1:0]  kind_r;
  logic [11:0] len_r;
  logic        pop_mode;

  slot_t mem [HISTORY];
  slot_t rd_data;
  logic [SLOT_W-1:0] rd_addr;

  logic [15:0] walk_n, chain_last, cons_n;
  logic [CNT_W-1:0] walk_cnt;
  logic        cons_first, over;
  logic [15:0] acc;
  res_t        res, out_r, res_done;
  logic        out_valid;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, max_msg};
  always_ff @(posedge clk) begin
    if (rst) begin
      max_msg <= MAX_MSG_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_msg <= pwdata[15:0];
    end
  end

  wire accept = items.valid && items.ready;
  assign items.ready = (state == ST_IDLE);

  // Decoded receive conditions.
  logic [15:0] next_seq;
  logic [1:0]  kind_eff;
  logic        in_window, in_order;
  assign next_seq  = seq_done + 16'd1;
  assign kind_eff  = (kind_r == 2'd3) ? KIND_WHOLE : kind_r;
  assign in_window = seq_lt(seq_done, seq_r) &&
                     !seq_lt(seq_done + 16'(HISTORY), seq_r);
  assign in_order  = (kind_eff == KIND_WHOLE) && (seq_r == next_seq);

  // Acknack over the valid bits.
  logic [15:0] ack_from, ack_count, ack_bits;
  logic [4:0]  ack_lim;
  always_comb begin
    logic found;
    found    = 1'b0;
    ack_from = seq_done;
    for (int i = 1; i <= HISTORY; i++) begin
      if (!found && !valid[slot_of(seq_done + 16'(i))]) begin
        found    = 1'b1;
        ack_from = seq_done + 16'(i);
      end
    end
    ack_count = seq_heard - (ack_from - 16'd1);
    ack_lim   = (ack_count < 16'd16) ? ack_count[4:0] : 5'd16;
    ack_bits  = '0;
    for (int i = 0; i < 16; i++) begin
      ack_bits[i] = (5'(i) < ack_lim) && !valid[slot_of(ack_from + 16'(i))];
    end
  end

  // Chain consume arithmetic.
  logic [16:0] sum_chk;
  logic        over_next;
  logic [15:0] acc_next;
  always_comb begin
    sum_chk   = 17'(rd_data.len) + 17'(acc);
    over_next = over;
    acc_next  = acc;
    if (cons_first) begin
      acc_next = 16'(payload_of(rd_data.len));
    end else if (!over && (sum_chk > 17'(max_msg))) begin
      over_next = 1'b1;
    end else if (!over) begin
      acc_next = acc + 16'(payload_of(rd_data.len));
    end
  end

  wire walk_empty = !valid[slot_of(walk_n)];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = ST_DONE;
        if (cmd_r == CMD_RECEIVE && in_window && !in_order && !valid[slot_of(seq_r)] &&
            kind_eff != KIND_WHOLE) begin
          state_next = ST_WALK_ISSUE;
        end else if (cmd_r == CMD_POP && valid[slot_of(next_seq)]) begin
          state_next = ST_WALK_ISSUE;
        end
      end
      ST_WALK_ISSUE: state_next = ST_WALK;
      ST_WALK: begin
        if (pop_mode && walk_cnt == '0 && rd_data.kind == KIND_WHOLE) begin
          state_next = ST_DONE;
        end else if (walk_empty) begin
          state_next = ST_DONE;
        end else if (rd_data.kind == KIND_LAST) begin
          state_next = pop_mode ? ST_CONS_ISSUE : ST_DONE;
        end else if (rd_data.kind != KIND_MID || walk_cnt == CNT_W'(HISTORY - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_CONS_ISSUE: state_next = ST_CONS;
      ST_CONS: if (cons_n == chain_last) state_next = ST_DONE;
      ST_DONE: if (!out_valid || results.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Read address of the slot memory.
  always_comb begin
    unique case (state)
      ST_WALK_ISSUE, ST_CONS_ISSUE: rd_addr = slot_of(next_seq);
      ST_WALK: rd_addr = slot_of(walk_n + 16'd1);
      ST_CONS: rd_addr = slot_of(cons_n + 16'd1);
      default: rd_addr = slot_of(next_seq);
    endcase
  end

  wire mem_we = (state == ST_EXEC) && (cmd_r == CMD_RECEIVE) && in_window && !in_order &&
                !valid[slot_of(seq_r)];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_of(seq_r)] <= '{len: len_r & 12'(MAX_SLOT_LENGTH), kind: kind_eff};
    end
    rd_data <= mem[rd_addr];
  end

  // Result as loaded into the output register.
  wire out_load = (state == ST_DONE) && (!out_valid || results.ready);
  always_comb begin
    res_done            = res;
    res_done.up_to_date = (seq_heard == seq_done);
  end

  // Datapath and window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seq_done  <= SEQ_RESET;
      seq_heard <= SEQ_RESET;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_r     <= res_done;
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_r  <= items.cmd;
            seq_r  <= items.seq_num;
            kind_r <= items.frag_kind;
            len_r  <= items.msg_length;
            res    <= '0;
          end
        end
        ST_EXEC: begin
          pop_mode <= (cmd_r == CMD_POP);
          case (cmd_r)
            CMD_RECEIVE: begin
              if (in_window) begin
                if (in_order) begin
                  seq_done     <= next_seq;
                  res.readable <= 1'b1;
                end else if (!valid[slot_of(seq_r)]) begin
                  valid[slot_of(seq_r)] <= ((len_r & 12'(MAX_SLOT_LENGTH)) != 12'd0);
                  res.stored <= 1'b1;
                end
              end
              if (seq_lt(seq_heard, seq_r)) seq_heard <= seq_r;
            end
            CMD_HEARTBEAT: begin
              if (seq_lt(seq_heard, seq_r)) seq_heard <= seq_r;
            end
            CMD_ACKNACK: begin
              res.first_seq <= ack_from;
              res.miss_mask <= ack_bits;
            end
            CMD_SOFT_RST: begin
              valid     <= '0;
              seq_done  <= SEQ_RESET;
              seq_heard <= SEQ_RESET;
            end
            default: ;
          endcase
        end
        ST_WALK_ISSUE: begin
          walk_n   <= next_seq;
          walk_cnt <= '0;
        end
        ST_WALK: begin
          walk_n   <= walk_n + 16'd1;
          walk_cnt <= walk_cnt + CNT_W'(1);
          if (pop_mode && walk_cnt == '0 && rd_data.kind == KIND_WHOLE) begin
            valid[slot_of(next_seq)] <= 1'b0;
            seq_done             <= next_seq;
            res.available        <= 1'b1;
            res.first_seq        <= next_seq;
            res.last_seq         <= next_seq;
            res.assembled_length <= 16'(rd_data.len);
          end else if (!walk_empty && rd_data.kind == KIND_LAST) begin
            chain_last <= walk_n;
            if (!pop_mode) res.readable <= 1'b1;
          end
        end
        ST_CONS_ISSUE: begin
          cons_n     <= next_seq;
          cons_first <= 1'b1;
          acc        <= '0;
          over       <= 1'b0;
        end
        ST_CONS: begin
          cons_n     <= cons_n + 16'd1;
          cons_first <= 1'b0;
          acc        <= acc_next;
          over       <= over_next;
          valid[slot_of(cons_n)] <= 1'b0;
          if (cons_n == chain_last) begin
            seq_done      <= chain_last;
            res.first_seq <= next_seq;
            res.last_seq  <= chain_last;
            if (over_next) begin
              res.oversize_drop <= 1'b1;
            end else begin
              res.available        <= 1'b1;
              res.assembled_length <= acc_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign results.valid            = out_valid;
  assign results.readable         = out_r.readable;
  assign results.stored           = out_r.stored;
  assign results.available        = out_r.available;
  assign results.first_seq        = out_r.first_seq;
  assign results.last_seq         = out_r.last_seq;
  assign results.assembled_length = out_r.assembled_length;
  assign results.oversize_drop    = out_r.oversize_drop;
  assign results.miss_mask        = out_r.miss_mask;
  assign results.up_to_date       = out_r.up_to_date;

  // Every slot consumed by a chain was filled.
  a_cons_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONS |-> valid[slot_of(cons_n)])
    else $error("consuming an empty slot");

  // A soft reset empties the whole window.
  a_soft_rst: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && cmd_r == CMD_SOFT_RST |=> valid == '0)
    else $error("slots left after soft reset");

  // A result is loaded only from the done state.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done");

  // The chain end found always lies within the window ahead of the handled number.
  a_chain_span: assert property (@(posedge clk) disable iff (rst)
    state == ST_CONS |-> (chain_last - seq_done) <= 16'(HISTORY))
    else $error("chain end out of window");

endmodule
`default_nettype wire
